>>> hdl/fmeg_pkg.sv
`default_nettype none
package fmeg_pkg;

  // Configuration register indexes on the write port.
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_LEVEL_OFFSET = 3'd0;
  localparam cfg_index_t REG_SCALE_DEPTH  = 3'd1;
  localparam cfg_index_t REG_ATK_SPEED    = 3'd2;
  localparam cfg_index_t REG_DEC_SPEED    = 3'd3;
  localparam cfg_index_t REG_SUS_SPEED    = 3'd4;
  localparam cfg_index_t REG_SUS_FLOOR    = 3'd5;
  localparam cfg_index_t REG_REL_SPEED    = 3'd6;

  // Item command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  // Attenuation limits.
  localparam logic [9:0] ATT_MAX     = 10'h3FF;
  localparam logic [9:0] SUSTAIN_TOP = 10'h3E0;
  localparam logic [5:0] RATE_MAX    = 6'd63;
  localparam logic [5:0] RATE_INSTANT = 6'd62;

  typedef struct packed {
    logic [6:0] level_offset;
    logic [1:0] scale_depth;
    logic [4:0] atk_speed;
    logic [4:0] dec_speed;
    logic [4:0] sus_speed;
    logic [3:0] sus_floor;
    logic [3:0] rel_speed;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic       key_level;
    logic [4:0] note_code;
  } item_t;

  typedef struct packed {
    logic [9:0] total_attenuation;
    logic       key_started;
  } res_t;

  // Rate scaled by the note code, clamped to six bits; a zero rate stays zero.
  function automatic logic [5:0] effective_rate(input logic [4:0] r,
                                                input logic [4:0] note_code,
                                                input logic [1:0] scale_depth);
    logic [6:0] e;
    e = {1'b0, r, 1'b0} + {2'b00, note_code >> (2'd3 - scale_depth)};
    if (r == 5'd0) begin
      return 6'd0;
    end
    return (e > {1'b0, RATE_MAX}) ? RATE_MAX : e[5:0];
  endfunction

  // True when the counter, masked by the rate group, allows a step.
  function automatic logic step_due(input logic [5:0] rate, input logic [10:0] counter);
    logic [3:0]  grp;
    logic [10:0] mask;
    grp  = rate[5:2];
    mask = (grp >= 4'd11) ? 11'd0 : (11'h7FF >> grp);
    return (counter & mask) == 11'd0;
  endfunction

  // Step delta table, 64 rates by 8 step indexes.
  function automatic logic [3:0] step_delta(input logic [5:0] rate, input logic [2:0] idx);
    logic [1:0] sel;
    logic [1:0] grp;
    logic [3:0] base;
    logic       bit_on;
    logic       hi;
    sel    = rate[1:0];
    grp    = 2'd0;
    base   = 4'd0;
    bit_on = 1'b0;
    hi     = 1'b0;
    if (rate < 6'd2) begin
      return 4'd0;
    end
    if (rate >= 6'd60) begin
      return 4'd8;
    end
    if (rate < 6'd48) begin
      // Low rates step by zero or one in a pattern set by the rate's low bits.
      if (rate < 6'd8) begin
        sel = (rate < 6'd6) ? 2'd0 : 2'd2;
      end
      unique case (sel)
        2'd0: bit_on = idx[0];
        2'd1: bit_on = idx[0] | (idx == 3'd4);
        2'd2: bit_on = (idx[1:0] != 2'd0);
        2'd3: bit_on = (idx != 3'd0);
      endcase
      return {3'b000, bit_on};
    end
    // High rates step by a power of two, doubled at some indexes.
    grp  = 2'((rate - 6'd48) >> 2);
    base = 4'd1 << grp;
    unique case (sel)
      2'd0: hi = 1'b0;
      2'd1: hi = (idx[1:0] == 2'd3);
      2'd2: hi = idx[0];
      2'd3: hi = (idx[1:0] != 2'd0);
    endcase
    return hi ? (base << 1) : base;
  endfunction

endpackage
`default_nettype wire

>>> hdl/fmeg_if.sv
`default_nettype none
// Input channel: one tick or key event per transaction.
interface fmeg_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       key_level;
  logic [4:0] note_code;

  modport source (output valid, output cmd, output key_level, output note_code, input ready);
  modport sink (input valid, input cmd, input key_level, input note_code, output ready);
endinterface

// Result channel: one attenuation result per transaction.
interface fmeg_result_if;
  logic       valid;
  logic       ready;
  logic [9:0] total_attenuation;
  logic       key_started;

  modport source (output valid, output total_attenuation, output key_started, input ready);
  modport sink (input valid, input total_attenuation, input key_started, output ready);
endinterface
`default_nettype wire

>>> hdl/fmeg_cfg_regs.sv
`default_nettype none
module fmeg_cfg_regs (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire fmeg_pkg::cfg_index_t  wr_index,
  input  wire logic [6:0]            wr_data,
  output fmeg_pkg::cfg_t             cfg
);
  import fmeg_pkg::*;

  // Register file; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_offset <= 7'd127;
      cfg.scale_depth  <= 2'd0;
      cfg.atk_speed    <= 5'd0;
      cfg.dec_speed    <= 5'd0;
      cfg.sus_speed    <= 5'd0;
      cfg.sus_floor    <= 4'd0;
      cfg.rel_speed    <= 4'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LEVEL_OFFSET: cfg.level_offset <= wr_data;
        REG_SCALE_DEPTH:  cfg.scale_depth  <= wr_data[1:0];
        REG_ATK_SPEED:    cfg.atk_speed    <= wr_data[4:0];
        REG_DEC_SPEED:    cfg.dec_speed    <= wr_data[4:0];
        REG_SUS_SPEED:    cfg.sus_speed    <= wr_data[4:0];
        REG_SUS_FLOOR:    cfg.sus_floor    <= wr_data[3:0];
        REG_REL_SPEED:    cfg.rel_speed    <= wr_data[3:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/fmeg_env_core.sv
`default_nettype none
module fmeg_env_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fmeg_pkg::cfg_t  cfg,
  input  wire logic            fire,
  input  wire fmeg_pkg::item_t item,
  output fmeg_pkg::res_t       res
);
  import fmeg_pkg::*;

  typedef enum logic [1:0] {PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE} phase_t;

  phase_t      phase, phase_next;
  logic [9:0]  attenuation, attenuation_next;
  logic        key_held, key_held_next;
  logic [1:0]  tick_divider, tick_divider_next;
  logic [10:0] rate_counter, rate_counter_next;
  logic [2:0]  step_index, step_index_next;

  logic [4:0]  phase_rate;
  logic [5:0]  rate;
  logic [5:0]  attack_eff;
  logic [1:0]  div_dec;
  logic        due;
  logic [3:0]  delta;
  logic [13:0] att_inv;
  logic [13:0] att_prod;
  logic [9:0]  attack_att;
  logic [10:0] added;
  logic [9:0]  sat_att;
  logic [9:0]  target;
  logic [10:0] sum;
  logic        started;

  // Rate of the current phase, scaled by the note code.
  always_comb begin
    unique case (phase)
      PH_ATTACK:  phase_rate = cfg.atk_speed;
      PH_DECAY:   phase_rate = cfg.dec_speed;
      PH_SUSTAIN: phase_rate = cfg.sus_speed;
      PH_RELEASE: phase_rate = {cfg.rel_speed, 1'b1};
    endcase
  end

  assign rate       = effective_rate(phase_rate, item.note_code, cfg.scale_depth);
  assign attack_eff = effective_rate(cfg.atk_speed, item.note_code, cfg.scale_depth);
  assign div_dec    = tick_divider - 2'd1;
  assign due        = step_due(rate, rate_counter);
  assign delta      = step_delta(rate, step_index);

  // Attack moves exponentially towards zero in 14-bit wrapping arithmetic.
  assign att_inv    = {4'hF, ~attenuation};
  assign att_prod   = att_inv * {10'd0, delta};
  assign attack_att = attenuation + att_prod[13:4];

  // Decay, sustain and release add the delta and saturate.
  assign added   = {1'b0, attenuation} + {7'd0, delta};
  assign sat_att = added[10] ? ATT_MAX : added[9:0];
  assign target  = (cfg.sus_floor == 4'hF) ? SUSTAIN_TOP : {1'b0, cfg.sus_floor, 5'd0};

  // Next state for one transaction.
  always_comb begin
    phase_next        = phase;
    attenuation_next  = attenuation;
    key_held_next     = key_held;
    tick_divider_next = tick_divider;
    rate_counter_next = rate_counter;
    step_index_next   = step_index;
    started           = 1'b0;
    if (item.cmd == CMD_TICK) begin
      if (div_dec != 2'd0) begin
        tick_divider_next = div_dec;
      end else begin
        tick_divider_next = 2'd3;
        rate_counter_next = rate_counter + 11'd1;
        if (due) begin
          step_index_next = step_index + 3'd1;
          unique case (phase)
            PH_ATTACK: begin
              attenuation_next = attack_att;
              if (attack_att == 10'd0) begin
                phase_next = PH_DECAY;
              end
            end
            PH_DECAY: begin
              attenuation_next = sat_att;
              if (sat_att >= target) begin
                phase_next = PH_SUSTAIN;
              end
            end
            PH_SUSTAIN, PH_RELEASE: begin
              attenuation_next = sat_att;
            end
          endcase
        end
      end
    end else if (item.key_level != key_held) begin
      key_held_next = item.key_level;
      if (item.key_level) begin
        started = 1'b1;
        // A very fast attack skips straight to decay at full volume.
        if (attack_eff >= RATE_INSTANT) begin
          phase_next       = PH_DECAY;
          attenuation_next = 10'd0;
        end else begin
          phase_next = PH_ATTACK;
        end
      end else begin
        phase_next = PH_RELEASE;
      end
    end
  end

  // Output level: attenuation plus total level, saturated.
  assign sum                   = {1'b0, attenuation_next} + {1'b0, cfg.level_offset, 3'b000};
  assign res.total_attenuation = sum[10] ? ATT_MAX : sum[9:0];
  assign res.key_started       = started;

  // Envelope state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ATTACK;
      attenuation  <= ATT_MAX;
      key_held     <= 1'b0;
      tick_divider <= 2'd1;
      rate_counter <= 11'd0;
      step_index   <= 3'd0;
    end else if (fire) begin
      phase        <= phase_next;
      attenuation  <= attenuation_next;
      key_held     <= key_held_next;
      tick_divider <= tick_divider_next;
      rate_counter <= rate_counter_next;
      step_index   <= step_index_next;
    end
  end

  // Only every third tick may move the envelope or its counter.
  a_skip_tick: assert property (@(posedge clk) disable iff (rst)
    fire && item.cmd == CMD_TICK && tick_divider != 2'd1
    |=> $stable(attenuation) && $stable(rate_counter) && $stable(step_index))
    else $error("envelope moved on a skipped tick");

  // The tick divider never rests at zero.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    tick_divider != 2'd0)
    else $error("tick divider reached zero");

  // A key-on with a very fast attack lands in decay at zero attenuation.
  a_instant_attack: assert property (@(posedge clk) disable iff (rst)
    fire && item.cmd == CMD_KEY && item.key_level && !key_held
    && attack_eff >= RATE_INSTANT
    |=> attenuation == 10'd0 && phase == PH_DECAY)
    else $error("instant attack did not reach decay");

endmodule
`default_nettype wire

>>> hdl/fm_adsr_envelope_generator_unit.sv
`default_nettype none
// FM operator envelope generator. Each input transaction (an envelope tick or a
// key event) yields exactly one result transaction carrying the total
// attenuation and a key-start flag. The unit sustains one transaction per clock
// cycle. An accepted item waits in the input register; the envelope state
// update that consumes it also loads the result register, from which the result
// is taken. That state update, which each item needs from the one before it,
// sets the rate. When the result is not taken, one item waits in each register
// and the input stalls. Configuration registers are written through the plain
// write port and should only change while the unit is idle.
module fm_adsr_envelope_generator_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  fmeg_item_if.sink                 item_in,
  fmeg_result_if.source             result_out,
  input  wire logic                 wr_en,
  input  wire fmeg_pkg::cfg_index_t wr_index,
  input  wire logic [6:0]           wr_data
);
  import fmeg_pkg::*;

  cfg_t  cfg;
  item_t in_q;
  logic  in_valid_q;
  res_t  res;
  res_t  out_res;
  logic  out_valid;
  logic  advance;

  fmeg_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  fmeg_env_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .item (in_q),
    .res  (res)
  );

  // The held item moves on when the result register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid || result_out.ready);
  assign item_in.ready = !in_valid_q || advance;

  // Input and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (item_in.ready) begin
        in_valid_q <= item_in.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      in_q <= '{cmd: item_in.cmd, key_level: item_in.key_level, note_code: item_in.note_code};
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign result_out.valid             = out_valid;
  assign result_out.total_attenuation = out_res.total_attenuation;
  assign result_out.key_started       = out_res.key_started;

  // A held item is kept intact until it is processed.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("held item lost or changed");

  // Every processed item leaves a result waiting.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item produced no result");

endmodule
`default_nettype wire

>>> dv/tb_fm_adsr_envelope_generator_unit.sv
`default_nettype none
module tb_fm_adsr_envelope_generator_unit;
  import fmeg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam cfg_index_t REG_UNMAPPED = 3'd7;

  // Envelope phases as the predictor tracks them.
  typedef enum logic [1:0] {
    EG_ATTACK  = 2'd0,
    EG_DECAY   = 2'd1,
    EG_SUSTAIN = 2'd2,
    EG_RELEASE = 2'd3
  } eg_phase_e;

  // Step delta rows, four bits per step index, index 0 in the low nibble.
  // Rates below 2 never step; rates from 2 to 47 use one of four zero-or-one
  // patterns; rates from 48 up have a row of their own.
  localparam logic [3:0][31:0] LOW_ROW = {
    32'h11111110, 32'h11101110, 32'h10111010, 32'h10101010
  };
  localparam logic [15:0][31:0] HIGH_ROW = {
    32'h88888888, 32'h88888888, 32'h88888888, 32'h88888888,
    32'h88848884, 32'h84848484, 32'h84448444, 32'h44444444,
    32'h44424442, 32'h42424242, 32'h42224222, 32'h22222222,
    32'h22212221, 32'h21212121, 32'h21112111, 32'h11111111
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  cfg_index_t wr_index = REG_LEVEL_OFFSET;
  logic [6:0] wr_data = 7'd0;

  fmeg_item_if item_if();
  fmeg_result_if res_if();

  fm_adsr_envelope_generator_unit dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (res_if),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  // Register copy and predicted envelope state.
  cfg_t regs = '{7'd127, 2'd0, 5'd0, 5'd0, 5'd0, 4'd0, 4'd0};
  logic [9:0]  env_att = 10'h3FF;
  eg_phase_e   env_phase = EG_ATTACK;
  logic        env_key = 1'b0;
  logic [1:0]  env_div = 2'd1;
  logic [10:0] env_cnt = 11'd0;
  logic [2:0]  env_idx = 3'd0;

  item_t pending_items[$];
  res_t  att_expected[$];

  logic offering = 1'b0;
  logic tx_gaps_on = 1'b1;
  logic rx_stalls_on = 1'b1;
  logic rx_hold_arm = 1'b0;
  logic rx_hold_taken = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned n_items = 0;
  int unsigned n_keys = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 0;
  int unsigned n_queued = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Rate of the current phase, scaled by the note code and clamped.
  function automatic logic [5:0] scaled_rate(logic [4:0] kc);
    logic [4:0] r;
    logic [6:0] kcs;
    logic [6:0] e;
    case (env_phase)
      EG_ATTACK:  r = regs.atk_speed;
      EG_DECAY:   r = regs.dec_speed;
      EG_SUSTAIN: r = regs.sus_speed;
      default:    r = {regs.rel_speed, 1'b1};
    endcase
    kcs = {2'b00, kc} >> (3 - regs.scale_depth);
    e = {1'b0, r, 1'b0} + kcs;
    if (r == 5'd0) return 6'd0;
    return (e > {1'b0, RATE_MAX}) ? RATE_MAX : e[5:0];
  endfunction

  // Advances the predicted envelope by one input item and returns its result.
  function automatic res_t envelope_step(item_t it);
    logic [5:0]  rate;
    logic [3:0]  grp;
    logic [10:0] mask;
    logic [31:0] row;
    logic [3:0]  delta;
    logic [13:0] p;
    logic [10:0] sum;
    logic [9:0]  target;
    res_t        r;
    r.key_started = 1'b0;
    if (it.cmd == CMD_TICK) begin
      env_div = env_div - 2'd1;
      if (env_div == 2'd0) begin
        env_div = 2'd3;
        rate = scaled_rate(it.note_code);
        grp = rate[5:2];
        mask = (grp >= 4'd11) ? 11'd0 : 11'((32'd1 << (11 - grp)) - 1);
        if ((env_cnt & mask) == 11'd0) begin
          if (rate < 6'd2) row = 32'd0;
          else if (rate < 6'd6) row = LOW_ROW[0];
          else if (rate < 6'd8) row = LOW_ROW[2];
          else if (rate < 6'd48) row = LOW_ROW[rate[1:0]];
          else row = HIGH_ROW[4'(rate - 6'd48)];
          delta = row[{env_idx, 2'b00} +: 4];
          env_idx = env_idx + 3'd1;
          target = (regs.sus_floor == 4'd15) ? SUSTAIN_TOP
                                             : {1'b0, regs.sus_floor, 5'b00000};
          if (env_phase == EG_ATTACK) begin
            // Exponential approach towards zero in 14-bit wrap arithmetic.
            p = (~{4'b0000, env_att}) * {10'd0, delta};
            env_att = env_att + p[13:4];
            if (env_att == 10'd0) env_phase = EG_DECAY;
          end else begin
            sum = {1'b0, env_att} + {7'd0, delta};
            env_att = (sum > {1'b0, ATT_MAX}) ? ATT_MAX : sum[9:0];
            if (env_phase == EG_DECAY && env_att >= target) env_phase = EG_SUSTAIN;
          end
        end
        env_cnt = env_cnt + 11'd1;
      end
    end else if (it.key_level != env_key) begin
      env_key = it.key_level;
      if (it.key_level) begin
        env_phase = EG_ATTACK;
        if (scaled_rate(it.note_code) >= RATE_INSTANT) begin
          env_phase = EG_DECAY;
          env_att = 10'd0;
        end
        r.key_started = 1'b1;
      end else begin
        env_phase = EG_RELEASE;
      end
    end
    sum = {1'b0, env_att} + {1'b0, regs.level_offset, 3'b000};
    r.total_attenuation = (sum > {1'b0, ATT_MAX}) ? ATT_MAX : sum[9:0];
    return r;
  endfunction

  // Driver: offers queued items and predicts each accepted transaction.
  always @(posedge clk) begin : driver_proc
    logic  nxt_valid;
    item_t got;
    item_t nxt;
    if (rst) begin
      item_if.valid <= 1'b0;
      offering = 1'b0;
      env_att = ATT_MAX;
      env_phase = EG_ATTACK;
      env_key = 1'b0;
      env_div = 2'd1;
      env_cnt = 11'd0;
      env_idx = 3'd0;
    end else begin
      nxt_valid = item_if.valid;
      if (item_if.valid && item_if.ready) begin
        got.cmd = item_if.cmd;
        got.key_level = item_if.key_level;
        got.note_code = item_if.note_code;
        att_expected.push_back(envelope_step(got));
        n_items++;
        if (got.cmd == CMD_KEY) n_keys++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          item_if.cmd <= nxt.cmd;
          item_if.key_level <= nxt.key_level;
          item_if.note_code <= nxt.note_code;
          nxt_valid = 1'b1;
          tx_gap = tx_gaps_on ? gap_len() : 0;
        end
      end
      item_if.valid <= nxt_valid;
      offering = nxt_valid;
    end
  end

  // Long receiver hold-off, started once when armed.
  always @(posedge clk) begin
    if (rx_hold_arm && !rx_hold_taken) begin
      rx_hold_left <= HOLD_CYCLES;
      rx_hold_taken <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin : monitor_proc
    res_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (att_expected.size() == 0) begin
          $error("result with nothing expected: total_attenuation %0d key_started %0d",
                 res_if.total_attenuation, res_if.key_started);
          fail_count++;
        end else begin
          want = att_expected.pop_front();
          if (res_if.total_attenuation !== want.total_attenuation) begin
            $error("total_attenuation: expected %0d, got %0d",
                   want.total_attenuation, res_if.total_attenuation);
            fail_count++;
          end
          if (res_if.key_started !== want.key_started) begin
            $error("key_started: expected %0d, got %0d",
                   want.key_started, res_if.key_started);
            fail_count++;
          end
        end
      end
      if (rx_stall != 0) rx_stall--;
      else if (rx_stalls_on) rx_stall = gap_len();
      res_if.ready <= (rx_stall == 0) && (rx_hold_left == 0);
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_item(logic cmd, logic level, logic [4:0] kc);
    item_t it;
    it.cmd = cmd;
    it.key_level = level;
    it.note_code = kc;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // One register write; the copy is updated as the write is issued.
  task automatic write_reg(cfg_index_t idx, logic [6:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_LEVEL_OFFSET: regs.level_offset = val;
      REG_SCALE_DEPTH:  regs.scale_depth = val[1:0];
      REG_ATK_SPEED:    regs.atk_speed = val[4:0];
      REG_DEC_SPEED:    regs.dec_speed = val[4:0];
      REG_SUS_SPEED:    regs.sus_speed = val[4:0];
      REG_SUS_FLOOR:    regs.sus_floor = val[3:0];
      REG_REL_SPEED:    regs.rel_speed = val[3:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(REG_LEVEL_OFFSET, c.level_offset);
    write_reg(REG_SCALE_DEPTH, c.scale_depth);
    write_reg(REG_ATK_SPEED, c.atk_speed);
    write_reg(REG_DEC_SPEED, c.dec_speed);
    write_reg(REG_SUS_SPEED, c.sus_speed);
    write_reg(REG_SUS_FLOOR, c.sus_floor);
    write_reg(REG_REL_SPEED, c.rel_speed);
    @(posedge clk);
    wr_en <= 1'b0;
    n_settings++;
  endtask

  // Waits until every offered transaction has produced its result.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || offering || att_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Attack and decay rates lean towards the fast end so that the envelope moves visibly.
  function automatic cfg_t pick_cfg();
    cfg_t c;
    c.level_offset = 7'($urandom_range(0, 127));
    c.scale_depth = 2'($urandom_range(0, 3));
    c.atk_speed = 5'(($urandom_range(0, 9) < 7) ? $urandom_range(18, 31)
                                                : $urandom_range(0, 31));
    c.dec_speed = 5'(($urandom_range(0, 9) < 7) ? $urandom_range(18, 31)
                                                : $urandom_range(0, 31));
    c.sus_speed = 5'($urandom_range(0, 31));
    c.sus_floor = 4'(($urandom_range(0, 9) < 6) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 15));
    c.rel_speed = 4'($urandom_range(0, 15));
    return c;
  endfunction

  // Key-on, a run of ticks, usually a key-off and more ticks, with noise between.
  task automatic run_sequences(int unsigned n);
    int unsigned start;
    int unsigned ticks;
    logic [4:0]  kc;
    start = n_queued;
    while (n_queued - start < n) begin
      if ($urandom_range(0, 9) == 0)
        push_item(1'($urandom), 1'($urandom), 5'($urandom));
      kc = 5'($urandom);
      push_item(CMD_KEY, 1'b1, kc);
      ticks = $urandom_range(4, 30);
      repeat (ticks)
        push_item(CMD_TICK, 1'($urandom),
                  ($urandom_range(0, 4) == 0) ? 5'($urandom) : kc);
      if ($urandom_range(0, 3) != 0) begin
        push_item(CMD_KEY, 1'b0, 5'($urandom));
        ticks = $urandom_range(2, 12);
        repeat (ticks) push_item(CMD_TICK, 1'($urandom), kc);
      end
    end
  endtask

  initial begin
    cfg_t c;
    int   ph;
    item_if.valid = 1'b0;
    item_if.cmd = CMD_TICK;
    item_if.key_level = 1'b0;
    item_if.note_code = 5'd0;
    res_if.ready = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // A tick under the reset register values saturates the output.
    push_item(CMD_TICK, 1'b0, 5'd0);
    wait_drained();

    // Directed part: instant attack, repeated key levels, attack from zero
    // wrapping to silence, release at the fastest rate.
    c = '{7'd0, 2'd3, 5'd30, 5'd31, 5'd31, 4'd15, 4'd15};
    program_regs(c);
    write_reg(REG_UNMAPPED, 7'($urandom));
    @(posedge clk);
    wr_en <= 1'b0;
    push_item(CMD_KEY, 1'b1, 5'd31);
    push_item(CMD_KEY, 1'b1, 5'd31);
    push_item(CMD_KEY, 1'b0, 5'd0);
    push_item(CMD_KEY, 1'b0, 5'd0);
    push_item(CMD_KEY, 1'b1, 5'd0);
    repeat (3) push_item(CMD_TICK, 1'b0, 5'd0);
    repeat (6) push_item(CMD_TICK, 1'b1, 5'd31);
    push_item(CMD_KEY, 1'b0, 5'd31);
    repeat (4) push_item(CMD_TICK, 1'b0, 5'd31);
    push_item(CMD_TICK, 1'b1, 5'd0);
    wait_drained();

    // Random part over several register settings, the extremes first.
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 0) c = '0;
      else if (ph == 1) c = '{7'd127, 2'd3, 5'd31, 5'd31, 5'd31, 4'd15, 4'd15};
      else c = pick_cfg();
      program_regs(c);
      tx_gaps_on = (ph != 2) && (ph != 3);
      rx_stalls_on = (ph != 3);
      if (ph == 2) rx_hold_arm = 1'b1;
      run_sequences(35);
      wait_drained();
    end

    $display("Covered %0d input transactions (%0d key events), %0d result transactions",
             n_items, n_keys, n_results);
    $display("over %0d register settings, with gap-free stretches and a long output stall.",
             n_settings);
    if (fail_count == 0 && att_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hdl/fmeg_pkg.sv
hdl/fmeg_if.sv
hdl/fmeg_cfg_regs.sv
hdl/fmeg_env_core.sv
hdl/fm_adsr_envelope_generator_unit.sv
dv/tb_fm_adsr_envelope_generator_unit.sv
